// ===== design/bcsg_pkg.sv =====
// Package: shared types, codes and constants for the battery charge-state gauge.
package bcsg_pkg;

  localparam int MvW    = 16;
  localparam int PctW   = 14;
  localparam int NumW   = 29;
  localparam int DivSteps = NumW;
  localparam int CntW   = $clog2(DivSteps);
  localparam int CfgIdxW = 2;

  localparam logic [PctW-1:0] PctFull     = PctW'(10000);
  localparam logic [PctW-1:0] PctLowBase  = PctW'(2000);
  localparam logic [PctW-1:0] PctZero     = '0;
  localparam logic [NumW-1:0] HighSpan    = NumW'(8000);
  localparam logic [NumW-1:0] LowSpan     = NumW'(2000);

  typedef enum logic [2:0] {
    CS_DISCHARGING = 3'd0,
    CS_LOW         = 3'd1,
    CS_DANGEROUS   = 3'd2,
    CS_CHARGING    = 3'd3,
    CS_FULL        = 3'd4
  } chg_state_t;

  typedef enum logic [1:0] {
    ACT_SAMPLE    = 2'd0,
    ACT_CHARGE    = 2'd1,
    ACT_FULL      = 2'd2,
    ACT_DISCHARGE = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    CFG_FULL   = 2'd0,
    CFG_LOW    = 2'd1,
    CFG_DANGER = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    F_IDLE = 3'd0,
    F_MUL  = 3'd1,
    F_DIV  = 3'd2,
    F_FIN  = 3'd3,
    F_DONE = 3'd4
  } fsm_t;

  typedef struct packed {
    logic accept;
    logic mul;
    logic step;
    logic finish;
    logic load_out;
  } bcsg_cmd_t;

  typedef struct packed {
    logic div_need;
  } bcsg_stat_t;

endpackage

// ===== design/bcsg_ctrl.sv =====
// Controller: request handshakes, sequencing of multiply and divide steps.
module bcsg_ctrl import bcsg_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  bcsg_stat_t stat,
  output bcsg_cmd_t  cmd
);

  fsm_t            state_r, state_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_free;
  logic            last_step;

  assign out_free  = !out_valid_r || !out_stall;
  assign last_step = (cnt_r == CntW'(DivSteps - 1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: if (in_valid) state_nxt = stat.div_need ? F_MUL : F_DONE;
      F_MUL:  state_nxt = F_DIV;
      F_DIV:  if (last_step) state_nxt = F_FIN;
      F_FIN:  state_nxt = F_DONE;
      F_DONE: if (out_free) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    cnt_nxt  = cnt_r;
    case (state_r)
      F_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      F_MUL: begin
        cmd.mul = 1'b1;
        cnt_nxt = '0;
      end
      F_DIV: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + CntW'(1);
      end
      F_FIN:  cmd.finish = 1'b1;
      F_DONE: cmd.load_out = out_free;
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= F_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== design/bcsg_dp.sv =====
// Datapath: thresholds, charge state, held values, multiplier and restoring divider.
module bcsg_dp import bcsg_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [MvW-1:0]     cfg_data,
  input  logic [1:0]         in_action,
  input  logic [MvW-1:0]     in_sample_mv,
  input  bcsg_cmd_t          cmd,
  output bcsg_stat_t         stat,
  output logic [2:0]         out_charge_state,
  output logic [MvW-1:0]     out_held_mv,
  output logic [PctW-1:0]    out_charge_percent,
  output logic               out_sample_taken,
  output logic               out_is_low,
  output logic               out_is_dangerous
);

  logic [MvW-1:0]  full_r, low_r, dang_r;
  chg_state_t      mode_r, mode_nxt;
  logic [MvW-1:0]  kept_mv_r;
  logic [PctW-1:0] kept_pct_r;
  logic            taken_r;
  logic [PctW-1:0] base_r;
  logic            sel_hi_r;
  logic [MvW-1:0]  diff_r, den_r;
  logic [NumW-1:0] num_r;
  logic [MvW-1:0]  rem_r;

  chg_state_t      o_state_r;
  logic [MvW-1:0]  o_mv_r;
  logic [PctW-1:0] o_pct_r;
  logic            o_taken_r, o_low_r, o_dang_r;

  act_t            act;
  logic            keep, above_low, above_dang, empty_span;
  logic [MvW:0]    trial;
  logic            trial_ge;
  logic [PctW-1:0] pct_fin;

  assign act        = act_t'(in_action);
  assign above_low  = in_sample_mv > low_r;
  assign above_dang = in_sample_mv > dang_r;
  assign empty_span = full_r <= low_r;

  always_comb begin
    if (mode_r inside {CS_CHARGING, CS_FULL})
      keep = (in_sample_mv > kept_mv_r) || (kept_mv_r == '0);
    else
      keep = (in_sample_mv < kept_mv_r) || (kept_mv_r == '0);
  end

  assign stat.div_need = (act == ACT_SAMPLE) && keep &&
                         (above_low ? !empty_span : above_dang);

  always_comb begin
    mode_nxt = mode_r;
    case (act)
      ACT_CHARGE:    mode_nxt = CS_CHARGING;
      ACT_FULL:      mode_nxt = CS_FULL;
      ACT_DISCHARGE: begin
        case (mode_r)
          CS_DISCHARGING: if (kept_mv_r <= low_r) mode_nxt = CS_LOW;
          CS_LOW:         if (kept_mv_r <= dang_r) mode_nxt = CS_DANGEROUS;
          CS_DANGEROUS:   mode_nxt = CS_DANGEROUS;
          default:        mode_nxt = CS_DISCHARGING;
        endcase
      end
      default: mode_nxt = mode_r;
    endcase
  end

  // one restoring step: shift in next numerator bit
  assign trial    = {rem_r, num_r[NumW-1]};
  assign trial_ge = trial >= {1'b0, den_r};

  // quotient above the high span saturates
  assign pct_fin = (num_r > HighSpan) ? PctFull : base_r + num_r[PctW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r     <= '0;
      low_r      <= '0;
      dang_r     <= '0;
      mode_r     <= CS_DISCHARGING;
      kept_mv_r  <= '0;
      kept_pct_r <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_idx_t'(cfg_index))
          CFG_FULL:   full_r <= cfg_data;
          CFG_LOW:    low_r  <= cfg_data;
          CFG_DANGER: dang_r <= cfg_data;
          default:    ;
        endcase
      end
      if (cmd.accept) begin
        mode_r <= mode_nxt;
        if (act == ACT_SAMPLE && keep) begin
          kept_mv_r <= in_sample_mv;
          if (!stat.div_need)
            kept_pct_r <= above_low ? PctFull : PctZero;
        end
      end
      if (cmd.finish) kept_pct_r <= pct_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      taken_r  <= (act == ACT_SAMPLE) && keep;
      sel_hi_r <= above_low;
      base_r   <= above_low ? PctLowBase : PctZero;
      diff_r   <= above_low ? in_sample_mv - low_r : in_sample_mv - dang_r;
      den_r    <= above_low ? full_r - low_r : low_r - dang_r;
    end
    if (cmd.mul) begin
      num_r <= NumW'(diff_r) * (sel_hi_r ? HighSpan : LowSpan);
      rem_r <= '0;
    end
    if (cmd.step) begin
      rem_r <= trial_ge ? MvW'(trial - {1'b0, den_r}) : trial[MvW-1:0];
      num_r <= {num_r[NumW-2:0], trial_ge};
    end
    if (cmd.load_out) begin
      o_state_r <= mode_r;
      o_mv_r    <= kept_mv_r;
      o_pct_r   <= kept_pct_r;
      o_taken_r <= taken_r;
      o_low_r   <= (mode_r == CS_LOW);
      o_dang_r  <= (mode_r == CS_DANGEROUS);
    end
  end

  assign out_charge_state   = o_state_r;
  assign out_held_mv        = o_mv_r;
  assign out_charge_percent = o_pct_r;
  assign out_sample_taken   = o_taken_r;
  assign out_is_low         = o_low_r;
  assign out_is_dangerous   = o_dang_r;

endmodule

// ===== design/battery_charge_state_gauge_unit.sv =====
// Top level: battery charge-state gauge, controller plus datapath.
// One request at a time. A command goes from the accepting cycle straight to
// the output load, which registers the result and raises out_valid. A kept
// sample between the dangerous threshold and a nonempty full range passes
// through the accepting cycle, the multiply step, the bit-serial restoring
// divider (one quotient bit per cycle), a finish step and the output load.
// Other samples go straight to the output load. The output load waits while
// a stalled result still fills the output register. The result sits in an
// output register, so the next request is taken while a result still waits.
// Configuration writes are always ready and take effect from the next kept
// sample on.
module battery_charge_state_gauge_unit import bcsg_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [MvW-1:0]     cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_action,
  input  logic [MvW-1:0]     in_sample_mv,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_charge_state,
  output logic [MvW-1:0]     out_held_mv,
  output logic [PctW-1:0]    out_charge_percent,
  output logic               out_sample_taken,
  output logic               out_is_low,
  output logic               out_is_dangerous
);

  bcsg_cmd_t  cmd;
  bcsg_stat_t stat;

  assign cfg_ready = 1'b1;

  bcsg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  bcsg_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_action          (in_action),
    .in_sample_mv       (in_sample_mv),
    .cmd                (cmd),
    .stat               (stat),
    .out_charge_state   (out_charge_state),
    .out_held_mv        (out_held_mv),
    .out_charge_percent (out_charge_percent),
    .out_sample_taken   (out_sample_taken),
    .out_is_low         (out_is_low),
    .out_is_dangerous   (out_is_dangerous)
  );

endmodule

// ===== design/bcsg_checker.sv =====
// Checker: port-level assertions for the gauge, bound to the top level.
module bcsg_checker import bcsg_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [2:0]         out_charge_state,
  input logic [MvW-1:0]     out_held_mv,
  input logic [PctW-1:0]    out_charge_percent,
  input logic               out_is_low,
  input logic               out_is_dangerous
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while another is in flight");

  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_low == (out_charge_state == CS_LOW)) &&
                  (out_is_dangerous == (out_charge_state == CS_DANGEROUS)))
    else $error("status flags disagree with charge state");

  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_charge_percent <= PctFull))
    else $error("charge level out of range");

  a_zero_mv: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_held_mv == '0) |-> (out_charge_percent == '0))
    else $error("nonzero level for zero held voltage");

endmodule

bind battery_charge_state_gauge_unit bcsg_checker u_bcsg_checker (.*);
